// ===== rtl/core/okm_pkg.sv =====
// ----------------------------------------------------------------------------
// okm_pkg
// Shared constants and types for the online k-means update core.
// ----------------------------------------------------------------------------
package okm_pkg;
  localparam int Clusters     = 8;
  localparam int Dimension    = 8;
  localparam int FractionBits = 8;
  localparam int SampleW      = 16;
  localparam int MeanW        = SampleW + FractionBits;
  localparam int CountW       = 32;
  localparam int CidxW        = 3;
  localparam int LiveW        = 4;
  localparam int DiffW        = MeanW + 1;
  localparam int SqW          = 2 * DiffW;
  localparam int DistW        = 64;
  localparam int MagW         = MeanW + CountW + 1;

  localparam logic CmdNearest = 1'b0;
  localparam logic CmdNamed   = 1'b1;

  typedef logic signed [MeanW-1:0] mean_t;
  typedef logic signed [SampleW-1:0] sample_t;

  // Control from the sequencer to the lanes.
  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
  } lane_ctl_t;
endpackage

// ===== rtl/core/okm_lane.sv =====
// ----------------------------------------------------------------------------
// okm_lane
// One vector element: squared difference for the search, and the bit-serial
// running-mean division for the update.
// ----------------------------------------------------------------------------
module okm_lane (
  input  logic                            clk,
  input  okm_pkg::lane_ctl_t              ctl,
  input  okm_pkg::sample_t                sample,
  input  okm_pkg::mean_t                  mean,
  input  logic [okm_pkg::CountW-1:0]      count,
  output logic [okm_pkg::SqW-1:0]         sq,
  output okm_pkg::mean_t                  new_mean
);
  localparam int MW = okm_pkg::MagW;
  localparam int CW = okm_pkg::CountW;

  logic signed [okm_pkg::MeanW-1:0] xf;
  logic signed [okm_pkg::DiffW-1:0] diff;
  logic [okm_pkg::DiffW-1:0] dmag;
  logic [okm_pkg::SqW-1:0] sq_reg;
  logic [MW-1:0] rem_q;
  logic [CW:0] rem;
  logic [CW:0] divisor;
  logic neg;
  logic [okm_pkg::MeanW-1:0] mmag, xmag;
  logic [MW-1:0] pm;
  logic [CW+1:0] trial;
  logic [CW:0] rnext;
  logic [MW-1:0] q;
  logic round_up;
  logic [okm_pkg::MeanW-1:0] qr;

  assign xf = okm_pkg::MeanW'({{okm_pkg::FractionBits{1'b0}}, sample} << okm_pkg::FractionBits);
  assign diff = okm_pkg::DiffW'(xf) - okm_pkg::DiffW'(mean);
  assign dmag = diff[okm_pkg::DiffW-1] ? okm_pkg::DiffW'(-diff) : okm_pkg::DiffW'(diff);

  always_ff @(posedge clk) begin
    if (ctl.load) sq_reg <= dmag * dmag;
  end
  assign sq = sq_reg;

  // Magnitude of mean*count + x. The product is registered before the add.
  assign mmag = mean[okm_pkg::MeanW-1] ? okm_pkg::MeanW'(-mean) : okm_pkg::MeanW'(mean);
  assign xmag = xf[okm_pkg::MeanW-1] ? okm_pkg::MeanW'(-xf) : okm_pkg::MeanW'(xf);

  always_ff @(posedge clk) begin
    if (ctl.load) pm <= MW'(mmag) * MW'(count);
  end

  // Restoring division: rem is the partial remainder; rem_q holds dividend and quotient bits.
  assign trial = {rem, rem_q[MW-1]} - {1'b0, divisor};
  assign rnext = trial[CW+1] ? {rem[CW-1:0], rem_q[MW-1]} : trial[CW:0];
  assign q = rem_q;
  assign round_up = ({1'b0, rem} >= ({1'b0, divisor} - {1'b0, rem}));
  assign qr = okm_pkg::MeanW'(q + MW'(round_up));

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      divisor <= {1'b0, count} + 1'b1;
      rem <= '0;
      if (mean[okm_pkg::MeanW-1] == xf[okm_pkg::MeanW-1]) begin
        rem_q <= pm + MW'(xmag);
        neg <= mean[okm_pkg::MeanW-1];
      end else if (pm >= MW'(xmag)) begin
        rem_q <= pm - MW'(xmag);
        neg <= mean[okm_pkg::MeanW-1];
      end else begin
        rem_q <= MW'(xmag) - pm;
        neg <= xf[okm_pkg::MeanW-1];
      end
    end else if (ctl.div_step) begin
      rem <= rnext;
      rem_q <= {rem_q[MW-2:0], ~trial[CW+1]};
    end
  end

  assign new_mean = neg ? okm_pkg::mean_t'(-qr) : okm_pkg::mean_t'(qr);
endmodule

// ===== rtl/core/okm_merge.sv =====
// ----------------------------------------------------------------------------
// okm_merge
// Adds the lane squares and keeps the running minimum.
// ----------------------------------------------------------------------------
module okm_merge (
  input  logic                                        clk,
  input  logic                                        clear,
  input  logic                                        take,
  input  logic [okm_pkg::CidxW-1:0]                   cand,
  input  logic [okm_pkg::Dimension*okm_pkg::SqW-1:0]  sqs,
  output logic [okm_pkg::CidxW-1:0]                   best_idx
);
  localparam int DW = okm_pkg::DistW;
  localparam int SW = okm_pkg::SqW;
  logic [SW-1:0] sq_pad [8];
  logic [SW:0] sum1 [4];
  logic [SW+1:0] sum2 [2];
  logic [DW-1:0] total;
  logic [DW-1:0] best;
  logic first;

  // Each square is below 2^49, so the sum of up to eight of them never comes
  // near the 64-bit width of the total and a plain adder tree is exact.
  always_comb begin
    for (int d = 0; d < 8; d++) begin
      sq_pad[d] = (d < okm_pkg::Dimension) ? sqs[d*SW +: SW] : '0;
    end
    for (int p = 0; p < 4; p++) begin
      sum1[p] = {1'b0, sq_pad[2*p]} + {1'b0, sq_pad[2*p+1]};
    end
    for (int p = 0; p < 2; p++) begin
      sum2[p] = {1'b0, sum1[2*p]} + {1'b0, sum1[2*p+1]};
    end
    total = DW'({1'b0, sum2[0]} + {1'b0, sum2[1]});
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      first <= 1'b1;
      best_idx <= '0;
    end else if (take) begin
      first <= 1'b0;
      if (first || total < best) begin
        best <= total;
        best_idx <= cand;
      end
    end
  end
endmodule

// ===== rtl/core/online_kmeans_update_core.sv =====
// ----------------------------------------------------------------------------
// online_kmeans_update_core
// Sequential (MacQueen) k-means: nearest-centroid search and running-mean
// update over eight parallel element lanes.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake        | Payload
// in      | into core | in_valid/stall   | command, target_cluster, element_0..7
// out     | from core | out_valid/stall  | cluster_index, created, rejected
//
// One item at a time. A seed or a reject is answered at its transfer edge.
// A nearest search steps through read, square and merge for each live cluster;
// every update then runs read, load, a 57-step bit-serial division and write.
// Reset clears the live-cluster count and the control state only; centroid
// and count entries are written when a cluster is seeded.
// A result waits in the output register while out_stall is high; the next
// input transfer is taken once that result has left.
// ----------------------------------------------------------------------------
module online_kmeans_update_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [0:0]           command,
  input  logic [3:0]           target_cluster,
  input  logic signed [15:0]   element_0,
  input  logic signed [15:0]   element_1,
  input  logic signed [15:0]   element_2,
  input  logic signed [15:0]   element_3,
  input  logic signed [15:0]   element_4,
  input  logic signed [15:0]   element_5,
  input  logic signed [15:0]   element_6,
  input  logic signed [15:0]   element_7,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           cluster_index,
  output logic                 created,
  output logic                 rejected
);
  localparam int D  = okm_pkg::Dimension;
  localparam int MW = okm_pkg::MeanW;
  localparam int CW = okm_pkg::CountW;
  localparam int IW = okm_pkg::CidxW;
  localparam int LW = okm_pkg::LiveW;
  localparam int StepW = 6;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD     = 3'd1;
  localparam logic [2:0] S_SQ     = 3'd2;
  localparam logic [2:0] S_MERGE  = 3'd3;
  localparam logic [2:0] S_URD    = 3'd4;
  localparam logic [2:0] S_ULOAD  = 3'd5;
  localparam logic [2:0] S_DIV    = 3'd6;
  localparam logic [2:0] S_WRITE  = 3'd7;

  logic [2:0] state;
  logic [LW-1:0] live;
  logic cmd;
  okm_pkg::sample_t x [D];
  okm_pkg::sample_t xin [D];
  logic [IW-1:0] scan;
  logic [IW-1:0] target;
  logic [StepW-1:0] step;

  assign xin[0] = element_0;
  assign xin[1] = element_1;
  assign xin[2] = element_2;
  assign xin[3] = element_3;
  assign xin[4] = element_4;
  assign xin[5] = element_5;
  assign xin[6] = element_6;
  assign xin[7] = element_7;

  // Centroid and count stores: registered-read RAMs.
  logic [IW-1:0] rd_addr;
  logic cen_we, cnt_we;
  logic [D*MW-1:0] cen_rd, cen_wd;
  logic [CW-1:0] cnt_rd, cnt_wd;
  logic [IW-1:0] wr_addr;

  okm_ram #(.Width(D*MW), .Depth(okm_pkg::Clusters)) u_cen (
    .clk(clk), .we(cen_we), .waddr(wr_addr), .wdata(cen_wd),
    .raddr(rd_addr), .rdata(cen_rd));
  okm_ram #(.Width(CW), .Depth(okm_pkg::Clusters)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(wr_addr), .wdata(cnt_wd),
    .raddr(rd_addr), .rdata(cnt_rd));

  okm_pkg::lane_ctl_t ctl;
  logic [D*okm_pkg::SqW-1:0] sqs;
  okm_pkg::mean_t nm [D];
  logic [IW-1:0] best_idx;
  logic [IW-1:0] cand;

  // A seed writes the incoming samples straight from the ports at the
  // transfer edge; an update writes the new means from the lanes.
  for (genvar g = 0; g < D; g++) begin : g_lane
    okm_lane u_lane (
      .clk(clk), .ctl(ctl), .sample(x[g]),
      .mean(okm_pkg::mean_t'(cen_rd[g*MW +: MW])), .count(cnt_rd),
      .sq(sqs[g*okm_pkg::SqW +: okm_pkg::SqW]), .new_mean(nm[g]));
    assign cen_wd[g*MW +: MW] = (state == S_WRITE) ? nm[g]
        : MW'({{okm_pkg::FractionBits{1'b0}}, xin[g]} << okm_pkg::FractionBits);
  end

  okm_merge u_merge (
    .clk(clk), .clear(state == S_IDLE), .take(state == S_MERGE),
    .cand(cand), .sqs(sqs), .best_idx(best_idx));

  logic accept;
  assign in_stall = (state != S_IDLE) || out_valid;
  assign accept = in_valid && !in_stall;

  // Seed/reject decision on the incoming item.
  logic seed_in, rej_in, full;
  logic [IW-1:0] idx_in;
  assign full = (live == LW'(okm_pkg::Clusters));
  always_comb begin
    seed_in = 1'b0;
    rej_in = 1'b0;
    idx_in = '0;
    if (command[0] == okm_pkg::CmdNearest) begin
      seed_in = (live == '0);
    end else if (target_cluster > live) begin
      rej_in = 1'b1;
    end else begin
      seed_in = (target_cluster == live);
      idx_in = target_cluster[IW-1:0];
    end
    if (seed_in && full) rej_in = 1'b1;
  end

  assign ctl.load = (state == S_SQ) || (state == S_ULOAD);
  assign ctl.div_start = (state == S_DIV) && (step == '0);
  assign ctl.div_step = (state == S_DIV) && (step != '0);

  // The update reads its cluster in S_URD (the search winner comes straight
  // from the merge stage) and keeps that address so the mean and the count
  // stay in front of the lanes until the write.
  assign rd_addr = (state == S_URD) ? ((cmd == okm_pkg::CmdNearest) ? best_idx : target)
                 : (state == S_ULOAD || state == S_DIV || state == S_WRITE) ? target
                 : scan;
  assign wr_addr = (state == S_WRITE) ? target : idx_in;
  assign cen_we = (state == S_WRITE) || (state == S_IDLE && accept && seed_in && !rej_in);
  assign cnt_we = cen_we;
  assign cnt_wd = (state == S_WRITE) ? ((cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1) : CW'(1);

  always_ff @(posedge clk) begin
    if (accept) begin
      x[0] <= element_0; x[1] <= element_1; x[2] <= element_2; x[3] <= element_3;
      x[4] <= element_4; x[5] <= element_5; x[6] <= element_6; x[7] <= element_7;
      cmd <= command[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      live <= '0;
      out_valid <= 1'b0;
      scan <= '0;
      cand <= '0;
      target <= '0;
      step <= '0;
      cluster_index <= '0;
      created <= 1'b0;
      rejected <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          scan <= '0;
          if (accept) begin
            target <= idx_in;
            if (rej_in || seed_in) begin
              out_valid <= 1'b1;
              cluster_index <= rej_in ? '0 : idx_in;
              created <= !rej_in;
              rejected <= rej_in;
              if (!rej_in) live <= live + 1'b1;
            end else if (command[0] == okm_pkg::CmdNearest) begin
              state <= S_RD;
            end else begin
              state <= S_URD;
            end
          end
        end
        S_RD: begin
          cand <= scan;
          state <= S_SQ;
        end
        S_SQ: state <= S_MERGE;
        S_MERGE: begin
          if ({1'b0, scan} == live - 1'b1) begin
            state <= S_URD;
          end else begin
            scan <= scan + 1'b1;
            state <= S_RD;
          end
        end
        S_URD: begin
          if (cmd == okm_pkg::CmdNearest) target <= best_idx;
          state <= S_ULOAD;
        end
        S_ULOAD: begin
          step <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (step == StepW'(okm_pkg::MagW)) state <= S_WRITE;
          step <= step + 1'b1;
        end
        S_WRITE: begin
          out_valid <= 1'b1;
          cluster_index <= target;
          created <= 1'b0;
          rejected <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live <= LW'(okm_pkg::Clusters)) else $error("live count overflow");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !accept) else $error("transfer taken while busy");
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rejected) |-> (cluster_index == '0 && !created))
    else $error("rejected result carries data");
endmodule

// ===== rtl/core/okm_ram.sv =====
// ----------------------------------------------------------------------------
// okm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module okm_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== test/online_kmeans_update_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// online_kmeans_update_core_tb
// Self-checking bench for the online k-means update core. A short table of
// directed vectors seeds and fills the cluster table, hits both reject paths
// and the extremes of the samples. Random vectors follow under three idling
// patterns. Every result is checked against a running-mean predictor kept in
// the bench, or against the result typed into its directed row.
// ----------------------------------------------------------------------------
module online_kmeans_update_core_tb;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [0:0] command;
  logic [3:0] target_cluster;
  logic signed [15:0] element_0, element_1, element_2, element_3;
  logic signed [15:0] element_4, element_5, element_6, element_7;
  logic out_valid;
  logic out_stall;
  logic [2:0] cluster_index;
  logic created;
  logic rejected;

  // One input vector, optionally with the result typed in by hand.
  typedef struct {
    logic [0:0] cmd;
    logic [3:0] tgt;
    logic [7:0][15:0] samples;
    bit known;
    logic [2:0] idx;
    logic cre;
    logic rej;
  } vector_row_t;

  typedef struct packed {
    logic [2:0] idx;
    logic cre;
    logic rej;
  } update_result_t;

  vector_row_t directed_rows[$];
  update_result_t pending_results[$];
  logic [7:0][15:0] seen_samples[$];

  // Predictor state: means on the fixed-point scale, member counts, live count.
  longint cluster_mean[okm_pkg::Clusters][okm_pkg::Dimension];
  logic [okm_pkg::CountW-1:0] cluster_members[okm_pkg::Clusters];
  int live_count;

  int tx_idle_pct;
  int rx_idle_pct;
  bit long_hold_req;
  int mismatches;

  online_kmeans_update_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .target_cluster(target_cluster),
    .element_0(element_0), .element_1(element_1),
    .element_2(element_2), .element_3(element_3),
    .element_4(element_4), .element_5(element_5),
    .element_6(element_6), .element_7(element_7),
    .out_valid(out_valid), .out_stall(out_stall),
    .cluster_index(cluster_index), .created(created), .rejected(rejected)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the core hangs.
  initial begin
    #20ms;
    $display("online_kmeans_update_core_tb NOT OK");
    $finish;
  end

  // Works out the result of one vector and moves the predictor state along.
  function automatic update_result_t apply_vector(input logic [0:0] cmd,
                                                  input logic [3:0] tgt,
                                                  input logic [7:0][15:0] samples);
    update_result_t res;
    longint xf[okm_pkg::Dimension];
    longint unsigned best, ssd, sq, m, cnt, dvs, pm, xm, mag, q, r;
    bit seed, neg, mneg, xneg;
    int pick;
    res = '0;
    seed = 1'b0;
    pick = 0;
    for (int d = 0; d < okm_pkg::Dimension; d++) begin
      xf[d] = longint'($signed(samples[d])) * (longint'(1) << okm_pkg::FractionBits);
    end
    if (cmd == okm_pkg::CmdNearest) begin
      if (live_count == 0) begin
        seed = 1'b1;
      end else begin
        best = 0;
        for (int c = 0; c < live_count; c++) begin
          ssd = 0;
          for (int d = 0; d < okm_pkg::Dimension; d++) begin
            m = (xf[d] >= cluster_mean[c][d]) ? xf[d] - cluster_mean[c][d]
                                              : cluster_mean[c][d] - xf[d];
            sq = m * m;
            ssd = (ssd > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                        : ssd + sq;
          end
          // Strict less-than keeps the lowest index on a tie.
          if (c == 0 || ssd < best) begin
            best = ssd;
            pick = c;
          end
        end
      end
    end else begin
      pick = tgt;
      if (pick > live_count) begin
        res.rej = 1'b1;
      end else if (pick == live_count) begin
        seed = 1'b1;
      end
    end
    if (seed && live_count >= okm_pkg::Clusters) res.rej = 1'b1;
    if (res.rej) return res;

    if (seed) begin
      for (int d = 0; d < okm_pkg::Dimension; d++) cluster_mean[pick][d] = xf[d];
      cluster_members[pick] = 1;
      live_count = pick + 1;
    end else begin
      cnt = cluster_members[pick];
      dvs = cnt + 1;
      for (int d = 0; d < okm_pkg::Dimension; d++) begin
        mneg = cluster_mean[pick][d] < 0;
        xneg = xf[d] < 0;
        pm = (mneg ? -cluster_mean[pick][d] : cluster_mean[pick][d]) * cnt;
        xm = xneg ? -xf[d] : xf[d];
        if (mneg == xneg) begin
          mag = pm + xm;
          neg = mneg;
        end else if (pm >= xm) begin
          mag = pm - xm;
          neg = mneg;
        end else begin
          mag = xm - pm;
          neg = xneg;
        end
        q = mag / dvs;
        r = mag % dvs;
        // Round half away from zero on the magnitude.
        if (r >= dvs - r) q++;
        cluster_mean[pick][d] = neg ? -longint'(q) : longint'(q);
      end
      if (cluster_members[pick] != {okm_pkg::CountW{1'b1}}) cluster_members[pick]++;
    end
    res.idx = pick[2:0];
    res.cre = seed;
    return res;
  endfunction

  // Appends one row to the directed table.
  function automatic void add_row(input logic [0:0] cmd, input logic [3:0] tgt,
                                  input logic [7:0][15:0] samples, input bit known,
                                  input logic [2:0] idx, input logic cre,
                                  input logic rej);
    vector_row_t row;
    row.cmd = cmd;
    row.tgt = tgt;
    row.samples = samples;
    row.known = known;
    row.idx = idx;
    row.cre = cre;
    row.rej = rej;
    directed_rows = {directed_rows, row};
  endfunction

  // Offers one vector and returns once the transfer has happened.
  task automatic send_vector(input vector_row_t row);
    update_result_t res;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= row.cmd;
    target_cluster <= row.tgt;
    {element_7, element_6, element_5, element_4,
     element_3, element_2, element_1, element_0} <= row.samples;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = apply_vector(row.cmd, row.tgt, row.samples);
    if (row.known) res = '{row.idx, row.cre, row.rej};
    pending_results = {pending_results, res};
  endtask

  // Random vectors: mostly nearest-assign, half near or on earlier samples so the search
  // sees close calls and exact ties, plus named adds that are often out of range.
  function automatic vector_row_t random_row();
    vector_row_t row;
    int mode;
    int base;
    row.known = 1'b0;
    row.cmd = ($urandom_range(0, 99) < 65) ? okm_pkg::CmdNearest : okm_pkg::CmdNamed;
    row.tgt = ($urandom_range(0, 99) < 60) ? 4'($urandom_range(0, live_count))
                                           : 4'($urandom_range(0, 15));
    mode = $urandom_range(0, 9);
    base = $urandom_range(0, seen_samples.size() - 1);
    for (int d = 0; d < okm_pkg::Dimension; d++) begin
      if (mode < 4) begin
        row.samples[d] = 16'($urandom);
      end else if (mode < 8) begin
        row.samples[d] = seen_samples[base][d] + 16'($urandom_range(0, 6) - 3);
      end else if (mode == 8) begin
        row.samples[d] = seen_samples[base][d];
      end else begin
        row.samples[d] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      end
    end
    return row;
  endfunction

  // Result side: random stall, with one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    update_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual idx=%0d created=%0b rejected=%0b",
                 $time, cluster_index, created, rejected);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (cluster_index !== want.idx) begin
          $display("%0t: cluster_index expected %0d actual %0d",
                   $time, want.idx, cluster_index);
          mismatches++;
        end
        if (created !== want.cre) begin
          $display("%0t: created expected %0b actual %0b", $time, want.cre, created);
          mismatches++;
        end
        if (rejected !== want.rej) begin
          $display("%0t: rejected expected %0b actual %0b", $time, want.rej, rejected);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int waited;
    vector_row_t row;
    logic [7:0][15:0] ramp;
    mismatches = 0;
    live_count = 0;
    long_hold_req = 1'b0;
    tx_idle_pct = 38;
    rx_idle_pct = 87;
    rst <= 1'b1;
    in_valid <= 1'b0;
    command <= okm_pkg::CmdNearest;
    target_cluster <= '0;
    {element_7, element_6, element_5, element_4,
     element_3, element_2, element_1, element_0} <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int d = 0; d < okm_pkg::Dimension; d++) ramp[d] = 16'(d * 1000 - 3500);

    // Directed table: seeding from empty, reject past the live count, extreme
    // samples, a tie between equally distant clusters, filling the table and
    // then refusing a further named seed.
    add_row(okm_pkg::CmdNearest, 4'd0, {8{16'h0000}}, 1, 3'd0, 1, 0);
    add_row(okm_pkg::CmdNamed, 4'd5, {8{16'h1234}}, 1, 3'd0, 0, 1);
    add_row(okm_pkg::CmdNamed, 4'd1, {8{16'h7FFF}}, 1, 3'd1, 1, 0);
    add_row(okm_pkg::CmdNamed, 4'd2, {8{16'h8000}}, 1, 3'd2, 1, 0);
    add_row(okm_pkg::CmdNearest, 4'd0, {8{16'h0000}}, 1, 3'd0, 0, 0);
    add_row(okm_pkg::CmdNamed, 4'd0, {8{16'h0001}}, 0, 0, 0, 0);
    add_row(okm_pkg::CmdNamed, 4'd1, {8{16'h8000}}, 0, 0, 0, 0);
    add_row(okm_pkg::CmdNamed, 4'd2, {8{16'h7FFF}}, 0, 0, 0, 0);
    add_row(okm_pkg::CmdNearest, 4'd9, {8{16'hFFFF}}, 0, 0, 0, 0);
    add_row(okm_pkg::CmdNamed, 4'd3, ramp, 1, 3'd3, 1, 0);
    add_row(okm_pkg::CmdNamed, 4'd4, ramp, 1, 3'd4, 1, 0);
    add_row(okm_pkg::CmdNearest, 4'd0, ramp, 0, 0, 0, 0);
    add_row(okm_pkg::CmdNamed, 4'd5, {8{16'h5555}}, 1, 3'd5, 1, 0);
    add_row(okm_pkg::CmdNamed, 4'd6, {8{16'hAAAA}}, 1, 3'd6, 1, 0);
    add_row(okm_pkg::CmdNamed, 4'd7, {8{16'h00FF}}, 1, 3'd7, 1, 0);
    add_row(okm_pkg::CmdNamed, 4'd8, {8{16'h0F0F}}, 1, 3'd0, 0, 1);
    add_row(okm_pkg::CmdNamed, 4'd15, {8{16'hF0F0}}, 1, 3'd0, 0, 1);
    add_row(okm_pkg::CmdNearest, 4'd6, {8{16'hAAAB}}, 0, 0, 0, 0);
    add_row(okm_pkg::CmdNamed, 4'd7, {8{16'hFF01}}, 0, 0, 0, 0);
    add_row(okm_pkg::CmdNearest, 4'd0, {8{16'h8000}}, 0, 0, 0, 0);

    foreach (directed_rows[i]) begin
      send_vector(directed_rows[i]);
      seen_samples = {seen_samples, directed_rows[i].samples};
    end

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 87 : 0;
      rx_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 38 : 0;
      for (int n = 0; n < 360; n++) begin
        // Once per phase, sit on the output for a long stretch while input keeps
        // coming, and once let the core drain completely before going on.
        if (n == 100) long_hold_req = 1'b1;
        if (n == 200) begin
          in_valid <= 1'b0;
          wait (pending_results.size() == 0);
        end
        row = random_row();
        send_vector(row);
        if (seen_samples.size() < 64) seen_samples = {seen_samples, row.samples};
        else seen_samples[$urandom_range(0, 63)] = row.samples;
      end
    end
    in_valid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("online_kmeans_update_core_tb OK");
    end else begin
      $display("online_kmeans_update_core_tb NOT OK");
    end
    $finish;
  end
endmodule
